// ===== hdl/rodr_pkg.sv =====
// shared types, constants and helper functions for the axis-angle to rotation matrix block
// no dependencies; imported by every module of the block
package rodr_pkg;

    // field widths of the item ports
    localparam int AXIS_BITS         = 16;
    localparam int ANGLE_BITS        = 16;
    localparam int ELEM_W            = 16;

    // cordic configuration
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int XY_W              = 34;
    localparam int Z_W               = 33;

    // quotient of the normalize division, Q1.15 before rounding
    localparam int Q_W               = 16;

    // width used for the clamp to one
    localparam int CLAMP_W           = 24;

    localparam logic signed [ELEM_W-1:0] ONE_Q14         = 16'sd16384;
    localparam logic [32:0]              TWO_PI_Q30      = 33'd6746518852;
    localparam logic signed [XY_W-1:0]   CORDIC_GAIN_Q30 = 34'sd652032874;

    // quadrant codes taken from the top two angle bits
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [AXIS_BITS-1:0] axis_x;
        logic signed [AXIS_BITS-1:0] axis_y;
        logic signed [AXIS_BITS-1:0] axis_z;
        logic [ANGLE_BITS-1:0]       angle;
    } t_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] r00;
        logic signed [ELEM_W-1:0] r01;
        logic signed [ELEM_W-1:0] r02;
        logic signed [ELEM_W-1:0] r10;
        logic signed [ELEM_W-1:0] r11;
        logic signed [ELEM_W-1:0] r12;
        logic signed [ELEM_W-1:0] r20;
        logic signed [ELEM_W-1:0] r21;
        logic signed [ELEM_W-1:0] r22;
        logic                     axis_zero;
    } t_out;

    // pipeline advance and stage valid, handed to every cell
    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

    // arctangent of 2^-i in Q2.30, truncated
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 33'sd843314856;
            5'd1:    v = 33'sd497837829;
            5'd2:    v = 33'sd263043836;
            5'd3:    v = 33'sd133525158;
            5'd4:    v = 33'sd67021686;
            5'd5:    v = 33'sd33543515;
            5'd6:    v = 33'sd16775850;
            5'd7:    v = 33'sd8388437;
            5'd8:    v = 33'sd4194282;
            5'd9:    v = 33'sd2097149;
            5'd10:   v = 33'sd1048575;
            5'd11:   v = 33'sd524287;
            5'd12:   v = 33'sd262143;
            5'd13:   v = 33'sd131071;
            5'd14:   v = 33'sd65535;
            5'd15:   v = 33'sd32767;
            5'd16:   v = 33'sd16383;
            5'd17:   v = 33'sd8191;
            5'd18:   v = 33'sd4095;
            5'd19:   v = 33'sd2047;
            5'd20:   v = 33'sd1023;
            5'd21:   v = 33'sd511;
            5'd22:   v = 33'sd255;
            5'd23:   v = 33'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    // saturate to the Q1.14 range of plus or minus one
    function automatic logic signed [ELEM_W-1:0] clamp_q14(input logic signed [CLAMP_W-1:0] v);
        logic signed [ELEM_W-1:0] r;
        if (v > CLAMP_W'(ONE_Q14)) begin
            r = ONE_Q14;
        end else if (v < -CLAMP_W'(ONE_Q14)) begin
            r = -ONE_Q14;
        end else begin
            r = ELEM_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== hdl/rodr_sqrt_cell.sv =====
// one cell of the integer square root chain: decides one root bit per item
// depends on rodr_pkg for the control struct
module rodr_sqrt_cell #(
    parameter int SQ_W   = 32,
    parameter int ROOT_W = 16,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rodr_pkg::t_ctl      i_ctl,
    input  logic [SQ_W-1:0]     i_rem,
    input  logic [ROOT_W-1:0]   i_root,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic [SQ_W-1:0]     o_rem,
    output logic [ROOT_W-1:0]   o_root,
    output logic [SIDE_W-1:0]   o_side
);
    import rodr_pkg::*;

    logic [SQ_W:0]      w_test;
    logic               w_take;
    logic [SQ_W-1:0]    n_rem;
    logic [ROOT_W-1:0]  n_root;
    logic               r_valid;
    logic [SQ_W-1:0]    r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [SIDE_W-1:0]  r_side;

    // trial subtrahend: 2*root*2^bit + 2^(2*bit)
    always_comb begin
        w_test = ((SQ_W+1)'(i_root) << (BIT + 1)) | ((SQ_W+1)'(1) << (2 * BIT));
        w_take = {1'b0, i_rem} >= w_test;
        n_rem  = w_take ? SQ_W'({1'b0, i_rem} - w_test) : i_rem;
        n_root = w_take ? (i_root | (ROOT_W'(1) << BIT)) : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

// ===== hdl/rodr_div_cell.sv =====
// one cell of the normalize divider chain: one quotient bit for each of three lanes
// depends on rodr_pkg for the control struct and quotient width
module rodr_div_cell #(
    parameter int DIV_W  = 17,
    parameter int MAG_W  = 16,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rodr_pkg::t_ctl                     i_ctl,
    input  logic [2:0][DIV_W-1:0]              i_rem,
    input  logic [2:0][rodr_pkg::Q_W-1:0]      i_quo,
    input  logic [MAG_W-1:0]                   i_mag,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    output logic [2:0][DIV_W-1:0]              o_rem,
    output logic [2:0][rodr_pkg::Q_W-1:0]      o_quo,
    output logic [MAG_W-1:0]                   o_mag,
    output logic [SIDE_W-1:0]                  o_side
);
    import rodr_pkg::*;

    logic [2:0][DIV_W-1:0]  w_trial;
    logic [2:0][DIV_W-1:0]  n_rem;
    logic [2:0][Q_W-1:0]    n_quo;
    logic                   r_valid;
    logic [2:0][DIV_W-1:0]  r_rem;
    logic [2:0][Q_W-1:0]    r_quo;
    logic [MAG_W-1:0]       r_mag;
    logic [SIDE_W-1:0]      r_side;

    // restoring step per lane; the top bit starts from the unshifted remainder
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_trial[l] = (BIT == Q_W - 1) ? i_rem[l] : (i_rem[l] << 1);
            if (w_trial[l] >= DIV_W'(i_mag)) begin
                n_rem[l] = w_trial[l] - DIV_W'(i_mag);
                n_quo[l] = i_quo[l] | (Q_W'(1) << BIT);
            end else begin
                n_rem[l] = w_trial[l];
                n_quo[l] = i_quo[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_mag  <= i_mag;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_mag   = r_mag;
    assign o_side  = r_side;

endmodule

// ===== hdl/rodr_cordic_cell.sv =====
// one rotation-mode cordic micro-rotation in Q2.30
// depends on rodr_pkg for widths and the arctangent table
module rodr_cordic_cell #(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rodr_pkg::t_ctl                       i_ctl,
    input  logic signed [rodr_pkg::XY_W-1:0]     i_x,
    input  logic signed [rodr_pkg::XY_W-1:0]     i_y,
    input  logic signed [rodr_pkg::Z_W-1:0]      i_z,
    input  logic [SIDE_W-1:0]                    i_side,
    output logic                                 o_valid,
    output logic signed [rodr_pkg::XY_W-1:0]     o_x,
    output logic signed [rodr_pkg::XY_W-1:0]     o_y,
    output logic signed [rodr_pkg::Z_W-1:0]      o_z,
    output logic [SIDE_W-1:0]                    o_side
);
    import rodr_pkg::*;

    logic signed [XY_W-1:0] w_dx;
    logic signed [XY_W-1:0] w_dy;
    logic signed [Z_W-1:0]  w_at;
    logic signed [XY_W-1:0] n_x;
    logic signed [XY_W-1:0] n_y;
    logic signed [Z_W-1:0]  n_z;
    logic                   r_valid;
    logic signed [XY_W-1:0] r_x;
    logic signed [XY_W-1:0] r_y;
    logic signed [Z_W-1:0]  r_z;
    logic [SIDE_W-1:0]      r_side;

    // rotate toward zero residual angle
    always_comb begin
        w_dx = i_y >>> STAGE;
        w_dy = i_x >>> STAGE;
        w_at = atan_q30(5'(STAGE));
        if (!i_z[Z_W-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - w_at;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

// ===== hdl/rodr_mat.sv =====
// matrix back end: quadrant fold of sine and cosine, axis-angle products, rounding
// depends on rodr_pkg for types, constants and the clamp function
module rodr_mat (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rodr_pkg::t_ctl                        i_ctl,
    input  logic signed [rodr_pkg::XY_W-1:0]      i_x,
    input  logic signed [rodr_pkg::XY_W-1:0]      i_y,
    input  logic [1:0]                            i_quad,
    input  logic [2:0][rodr_pkg::ELEM_W-1:0]      i_n,
    input  logic                                  i_zero,
    output logic                                  o_valid,
    output rodr_pkg::t_out                        o_res
);
    import rodr_pkg::*;

    localparam int P_W = 2 * ELEM_W;
    localparam int T_W = 52;

    // fold stage
    logic signed [XY_W:0]        w_xr;
    logic signed [XY_W:0]        w_yr;
    logic signed [ELEM_W-1:0]    w_cr;
    logic signed [ELEM_W-1:0]    w_sr;
    logic signed [ELEM_W-1:0]    n_c;
    logic signed [ELEM_W-1:0]    n_s;
    logic                        r1_valid;
    logic signed [ELEM_W-1:0]    r1_c;
    logic signed [ELEM_W-1:0]    r1_s;
    logic [2:0][ELEM_W-1:0]      r1_n;
    logic                        r1_zero;

    // product stage
    logic signed [ELEM_W-1:0]    w_k [9];
    logic signed [P_W-1:0]       n_p [9];
    logic signed [P_W-1:0]       n_sk [9];
    logic                        r2_valid;
    logic signed [P_W-1:0]       r2_p [9];
    logic signed [P_W-1:0]       r2_sk [9];
    logic signed [ELEM_W:0]      r2_omc;
    logic signed [ELEM_W-1:0]    r2_c;
    logic                        r2_zero;

    // sum stage
    logic signed [T_W-1:0]       n_t [9];
    logic                        r3_valid;
    logic signed [T_W-1:0]       r3_t [9];
    logic                        r3_zero;

    // round stage
    logic signed [T_W-1:0]       w_rnd [9];
    logic signed [ELEM_W-1:0]    n_e [9];
    logic                        r4_valid;
    logic signed [ELEM_W-1:0]    r4_e [9];
    logic                        r4_zero;

    // round residual cos and sin to Q1.14, then place them in their quadrant
    always_comb begin
        w_xr = ((XY_W+1)'(i_x) + (XY_W+1)'(33'sd32768)) >>> 16;
        w_yr = ((XY_W+1)'(i_y) + (XY_W+1)'(33'sd32768)) >>> 16;
        w_cr = clamp_q14(CLAMP_W'(w_xr));
        w_sr = clamp_q14(CLAMP_W'(w_yr));
        case (i_quad)
            QUAD_0: begin
                n_c = w_cr;
                n_s = w_sr;
            end
            QUAD_1: begin
                n_c = -w_sr;
                n_s = w_cr;
            end
            QUAD_2: begin
                n_c = -w_cr;
                n_s = -w_sr;
            end
            default: begin
                n_c = w_sr;
                n_s = -w_cr;
            end
        endcase
    end

    // skew matrix of n and the two products per element
    always_comb begin
        w_k[0] = '0;
        w_k[1] = -$signed(r1_n[2]);
        w_k[2] = $signed(r1_n[1]);
        w_k[3] = $signed(r1_n[2]);
        w_k[4] = '0;
        w_k[5] = -$signed(r1_n[0]);
        w_k[6] = -$signed(r1_n[1]);
        w_k[7] = $signed(r1_n[0]);
        w_k[8] = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_p[i*3+j]  = P_W'($signed(r1_n[i])) * P_W'($signed(r1_n[j]));
                n_sk[i*3+j] = P_W'(r1_s) * P_W'(w_k[i*3+j]);
            end
        end
    end

    // (1 - cos) n_i n_j + sin k_ij + cos on the diagonal, scaled to 2^42
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_t[i*3+j] = T_W'(r2_omc) * T_W'(r2_p[i*3+j])
                           + (T_W'(r2_sk[i*3+j]) <<< 14)
                           + ((i == j) ? (T_W'(r2_c) <<< 28) : T_W'(0));
            end
        end
    end

    // round to nearest at bit 28 and clamp
    always_comb begin
        for (int e = 0; e < 9; e++) begin
            w_rnd[e] = (r3_t[e] + (T_W'(1) <<< 27)) >>> 28;
            n_e[e]   = clamp_q14(CLAMP_W'(w_rnd[e]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r1_valid <= i_ctl.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r1_c    <= n_c;
            r1_s    <= n_s;
            r1_n    <= i_n;
            r1_zero <= i_zero;
            r2_p    <= n_p;
            r2_sk   <= n_sk;
            r2_omc  <= (ELEM_W+1)'(ONE_Q14) - (ELEM_W+1)'(r1_c);
            r2_c    <= r1_c;
            r2_zero <= r1_zero;
            r3_t    <= n_t;
            r3_zero <= r2_zero;
            r4_e    <= n_e;
            r4_zero <= r3_zero;
        end
    end

    // zero axis gives the identity
    always_comb begin
        o_valid         = r4_valid;
        o_res.axis_zero = r4_zero;
        o_res.r00 = r4_zero ? ONE_Q14 : r4_e[0];
        o_res.r01 = r4_zero ? '0      : r4_e[1];
        o_res.r02 = r4_zero ? '0      : r4_e[2];
        o_res.r10 = r4_zero ? '0      : r4_e[3];
        o_res.r11 = r4_zero ? ONE_Q14 : r4_e[4];
        o_res.r12 = r4_zero ? '0      : r4_e[5];
        o_res.r20 = r4_zero ? '0      : r4_e[6];
        o_res.r21 = r4_zero ? '0      : r4_e[7];
        o_res.r22 = r4_zero ? ONE_Q14 : r4_e[8];
    end

endmodule

// ===== hdl/axis_angle_to_rotation_matrix.sv =====
// axis-angle to rotation matrix, fully pipelined: one item per clock while the output
// is not stalled; the front register, the square root cell chain, the divider cell chain,
// the cordic cell chain and the matrix back end stand in series.
// the whole pipe holds while a finished item waits under output stall.
// synchronous active-low reset clears all valid bits; no other state.
// depends on rodr_pkg, rodr_sqrt_cell, rodr_div_cell, rodr_cordic_cell, rodr_mat
module axis_angle_to_rotation_matrix #(
    parameter int CORDIC_STAGES = rodr_pkg::CORDIC_STAGES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  rodr_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output rodr_pkg::t_out  o_data
);
    import rodr_pkg::*;

    localparam int A       = AXIS_BITS;
    localparam int SQ_W    = 2 * A;
    localparam int DIV_W   = A + 1;
    localparam int PROD_W  = ANGLE_BITS - 2 + 33;
    localparam int SIDE1_W = 3 + 3 * A + 1 + 2 + Z_W;
    localparam int SIDE2_W = 3 + 1 + 2 + Z_W;
    localparam int SIDE3_W = 1 + 2 + 3 * ELEM_W;

    logic                   w_en;
    logic                   w_mat_valid;
    t_out                   w_mat_res;

    // front stage
    logic [A-1:0]           n_m [3];
    logic [2:0]             n_sign;
    logic [SQ_W-1:0]        n_sq;
    logic [PROD_W-1:0]      w_prod;
    logic signed [Z_W-1:0]  n_z;
    logic                   r0_valid;
    logic [A-1:0]           r0_m [3];
    logic [2:0]             r0_sign;
    logic [SQ_W-1:0]        r0_sq;
    logic signed [Z_W-1:0]  r0_z;
    logic [1:0]             r0_quad;
    logic                   r0_zero;

    // square root chain
    logic                   w_sq_valid [A+1];
    logic [SQ_W-1:0]        w_sq_rem   [A+1];
    logic [A-1:0]           w_sq_root  [A+1];
    logic [SIDE1_W-1:0]     w_sq_side  [A+1];

    // divider chain
    logic                   w_dv_valid [Q_W+1];
    logic [2:0][DIV_W-1:0]  w_dv_rem   [Q_W+1];
    logic [2:0][Q_W-1:0]    w_dv_quo   [Q_W+1];
    logic [A-1:0]           w_dv_mag   [Q_W+1];
    logic [SIDE2_W-1:0]     w_dv_side  [Q_W+1];

    // cordic chain
    logic                   w_cr_valid [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] w_cr_x     [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] w_cr_y     [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  w_cr_z     [CORDIC_STAGES+1];
    logic [SIDE3_W-1:0]     w_cr_side  [CORDIC_STAGES+1];

    // normalized axis between divider and cordic
    logic [2:0]             w_dv_sign;
    logic                   w_dv_zero;
    logic [1:0]             w_dv_quad;
    logic signed [Z_W-1:0]  w_dv_z;
    logic [Q_W:0]           w_qp [3];
    logic [2:0][ELEM_W-1:0] w_n;
    logic [2:0][ELEM_W-1:0] w_mat_n;
    logic [1:0]             w_mat_quad;
    logic                   w_mat_zero;

    // whole pipe advances unless a finished item is held
    assign w_en    = !(w_mat_valid && i_stall);
    assign o_stall = !w_en;

    // magnitudes, sum of squares, quadrant and residual angle in Q2.30
    always_comb begin
        n_m[0]    = i_data.axis_x[A-1] ? A'(-i_data.axis_x) : A'(i_data.axis_x);
        n_m[1]    = i_data.axis_y[A-1] ? A'(-i_data.axis_y) : A'(i_data.axis_y);
        n_m[2]    = i_data.axis_z[A-1] ? A'(-i_data.axis_z) : A'(i_data.axis_z);
        n_sign    = {i_data.axis_z[A-1], i_data.axis_y[A-1], i_data.axis_x[A-1]};
        n_sq      = SQ_W'(n_m[0]) * SQ_W'(n_m[0]) + SQ_W'(n_m[1]) * SQ_W'(n_m[1])
                  + SQ_W'(n_m[2]) * SQ_W'(n_m[2]);
        w_prod    = PROD_W'(i_data.angle[ANGLE_BITS-3:0]) * PROD_W'(TWO_PI_Q30);
        n_z       = Z_W'(w_prod >> ANGLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_m    <= n_m;
            r0_sign <= n_sign;
            r0_sq   <= n_sq;
            r0_z    <= n_z;
            r0_quad <= i_data.angle[ANGLE_BITS-1 -: 2];
            r0_zero <= (i_data.axis_x == '0) && (i_data.axis_y == '0)
                    && (i_data.axis_z == '0);
        end
    end

    // square root: one root bit per cell, most significant first
    assign w_sq_valid[0] = r0_valid;
    assign w_sq_rem[0]   = r0_sq;
    assign w_sq_root[0]  = '0;
    assign w_sq_side[0]  = {r0_sign, r0_m[2], r0_m[1], r0_m[0], r0_zero, r0_quad, r0_z};

    for (genvar k = 0; k < A; k++) begin : g_sqrt
        rodr_sqrt_cell #(
            .SQ_W   (SQ_W),
            .ROOT_W (A),
            .BIT    (A - 1 - k),
            .SIDE_W (SIDE1_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   ('{en: w_en, valid: w_sq_valid[k]}),
            .i_rem   (w_sq_rem[k]),
            .i_root  (w_sq_root[k]),
            .i_side  (w_sq_side[k]),
            .o_valid (w_sq_valid[k+1]),
            .o_rem   (w_sq_rem[k+1]),
            .o_root  (w_sq_root[k+1]),
            .o_side  (w_sq_side[k+1])
        );
    end

    // divider: each lane computes |a_i| * 2^15 / |a|
    assign w_dv_valid[0] = w_sq_valid[A];
    assign w_dv_mag[0]   = w_sq_root[A];
    assign w_dv_quo[0]   = '0;
    assign w_dv_rem[0]   = {
        DIV_W'(w_sq_side[A][Z_W+3+2*A +: A]),
        DIV_W'(w_sq_side[A][Z_W+3+A +: A]),
        DIV_W'(w_sq_side[A][Z_W+3 +: A])
    };
    assign w_dv_side[0]  = {w_sq_side[A][SIDE1_W-1 -: 3], w_sq_side[A][Z_W+2 : 0]};

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        rodr_div_cell #(
            .DIV_W  (DIV_W),
            .MAG_W  (A),
            .BIT    (Q_W - 1 - k),
            .SIDE_W (SIDE2_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   ('{en: w_en, valid: w_dv_valid[k]}),
            .i_rem   (w_dv_rem[k]),
            .i_quo   (w_dv_quo[k]),
            .i_mag   (w_dv_mag[k]),
            .i_side  (w_dv_side[k]),
            .o_valid (w_dv_valid[k+1]),
            .o_rem   (w_dv_rem[k+1]),
            .o_quo   (w_dv_quo[k+1]),
            .o_mag   (w_dv_mag[k+1]),
            .o_side  (w_dv_side[k+1])
        );
    end

    // round the quotient to Q1.14 and restore the sign
    always_comb begin
        {w_dv_sign, w_dv_zero, w_dv_quad, w_dv_z} = w_dv_side[Q_W];
        for (int l = 0; l < 3; l++) begin
            w_qp[l] = (Q_W+1)'(w_dv_quo[Q_W][l]) + (Q_W+1)'(1);
            w_n[l]  = w_dv_sign[l] ? ELEM_W'(-w_qp[l][Q_W:1]) : ELEM_W'(w_qp[l][Q_W:1]);
        end
    end

    // cordic: one micro-rotation per cell
    assign w_cr_valid[0] = w_dv_valid[Q_W];
    assign w_cr_x[0]     = CORDIC_GAIN_Q30;
    assign w_cr_y[0]     = '0;
    assign w_cr_z[0]     = w_dv_z;
    assign w_cr_side[0]  = {w_dv_zero, w_dv_quad, w_n};

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        rodr_cordic_cell #(
            .STAGE  (k),
            .SIDE_W (SIDE3_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   ('{en: w_en, valid: w_cr_valid[k]}),
            .i_x     (w_cr_x[k]),
            .i_y     (w_cr_y[k]),
            .i_z     (w_cr_z[k]),
            .i_side  (w_cr_side[k]),
            .o_valid (w_cr_valid[k+1]),
            .o_x     (w_cr_x[k+1]),
            .o_y     (w_cr_y[k+1]),
            .o_z     (w_cr_z[k+1]),
            .o_side  (w_cr_side[k+1])
        );
    end

    assign {w_mat_zero, w_mat_quad, w_mat_n} = w_cr_side[CORDIC_STAGES];

    // matrix back end and output register
    rodr_mat u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: w_en, valid: w_cr_valid[CORDIC_STAGES]}),
        .i_x     (w_cr_x[CORDIC_STAGES]),
        .i_y     (w_cr_y[CORDIC_STAGES]),
        .i_quad  (w_mat_quad),
        .i_n     (w_mat_n),
        .i_zero  (w_mat_zero),
        .o_valid (w_mat_valid),
        .o_res   (w_mat_res)
    );

    assign o_valid = w_mat_valid;
    assign o_data  = w_mat_res;

endmodule
